// File: src/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the CRC byte update for the command frame
// builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam logic [15:0] CRC_SEED = 16'hC181;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] ID_MAX   = 16'd1023;

  localparam int PCNT_W            = 8;
  localparam int PAYLOAD_LIMIT_DEF = 128;
  localparam int TOK_DEPTH_DEF     = 4;
  localparam int OUT_DEPTH_DEF     = 4;

  // one frame segment, as classified by the front end
  typedef struct packed {
    logic       do_hdr;
    logic       do_pb;
    logic       do_end;
    logic       hdr_err;
    logic       pb_err;
    logic       end_err;
    logic [7:0] id_lo;
    logic [1:0] id_hi;
    logic [7:0] cmd;
    logic [7:0] pb;
  } tok_t;

  // one result word
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_error;
    logic       frame_end;
  } res_t;

  // reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: src/command_frame_builder_crc16.sv
// ----------------------------------------------------------------------------
// command_frame_builder_crc16
// Command frame builder: 10-bit id, command, payload, reflected CRC-16
// (poly 0xA001, seed 0xC181), with error word on bad id or long payload.
// ----------------------------------------------------------------------------
//
//  channel  | handshake        | words
//  ---------+------------------+----------------------------------------------
//  in_      | push / full      | id, command, payload byte and frame flags
//  out_     | pop / empty      | frame byte, error flag, end-of-frame flag
//
// Rate: the front end takes one word per cycle while full is low; the back
// end writes one result word per cycle while the result queue has room, so
// a word's results go out one per cycle (one for a payload byte, up to six
// with header and CRC), made by the back end's byte sequencer and CRC register.
// Reset: synchronous, active low; both queues empty, CRC at seed.
// Stalls: full rises when the segment queue is full; the back end pauses
// while the result queue is full. Words are registered in both queues.
//
module command_frame_builder_crc16
  import cfb_pkg::*;
#(
  parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF,
  parameter int TOK_DEPTH     = TOK_DEPTH_DEF,
  parameter int OUT_DEPTH     = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_target_id,
  input  logic [7:0]  in_command_code,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_has_byte,
  input  logic        in_first_item,
  input  logic        in_last_item,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_error,
  output logic        out_frame_end
);

  tok_t fe_tok, q_tok;
  logic fe_vld, accept;
  logic tok_full, tok_empty, tok_pop;
  res_t be_res, q_res;
  logic res_push, res_full;

  // a word is taken whenever the segment queue has room, even if it
  // yields no segment at all
  assign full   = tok_full;
  assign accept = push && !tok_full;

  cfb_front #(
    .PAYLOAD_LIMIT(PAYLOAD_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .target_id    (in_target_id),
    .command_code (in_command_code),
    .payload_byte (in_payload_byte),
    .has_byte     (in_has_byte),
    .first_item   (in_first_item),
    .last_item    (in_last_item),
    .tok          (fe_tok),
    .tok_vld      (fe_vld)
  );

  // segment queue between classifier and sequencer
  cfb_fifo #(
    .WIDTH($bits(tok_t)),
    .DEPTH(TOK_DEPTH)
  ) u_tok_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept && fe_vld),
    .wr_data (fe_tok),
    .full    (tok_full),
    .pop     (tok_pop),
    .rd_data (q_tok),
    .empty   (tok_empty)
  );

  cfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (q_tok),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .res       (be_res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // result queue decouples the sequencer from the consumer
  cfb_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (be_res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (q_res),
    .empty   (empty)
  );

  assign out_frame_byte  = q_res.frame_byte;
  assign out_frame_error = q_res.frame_error;
  assign out_frame_end   = q_res.frame_end;

endmodule

// File: src/cfb_fifo.sv
// ----------------------------------------------------------------------------
// cfb_fifo
// Small register FIFO, used for the segment queue and the result queue.
// ----------------------------------------------------------------------------
module cfb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fifo count beyond depth");

endmodule

// File: src/cfb_front.sv
// ----------------------------------------------------------------------------
// cfb_front
// Classifies each accepted word into a frame segment and tracks payload
// count and error state.
// ----------------------------------------------------------------------------
module cfb_front
  import cfb_pkg::*;
#(
  parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [15:0] target_id,
  input  logic [7:0]  command_code,
  input  logic [7:0]  payload_byte,
  input  logic        has_byte,
  input  logic        first_item,
  input  logic        last_item,
  output tok_t        tok,
  output logic        tok_vld
);

  logic [PCNT_W-1:0] cnt_r, cnt_nxt;
  logic              err_r, err_nxt;
  logic [PCNT_W-1:0] cnt0, cnt1;
  logic              err0, err1, pb_ok;

  always_comb begin
    cnt0  = first_item ? '0 : cnt_r;
    err0  = first_item ? (target_id > ID_MAX) : err_r;
    pb_ok = has_byte && (cnt0 < PCNT_W'(PAYLOAD_LIMIT));
    cnt1  = pb_ok ? cnt0 + 1'b1 : cnt0;
    err1  = err0 | (pb_ok && (cnt1 == PCNT_W'(PAYLOAD_LIMIT)));

    tok.do_hdr  = first_item;
    tok.do_pb   = pb_ok;
    tok.do_end  = last_item;
    tok.hdr_err = err0;
    tok.pb_err  = err1;
    tok.end_err = err1;
    tok.id_lo   = target_id[7:0];
    tok.id_hi   = target_id[9:8];
    tok.cmd     = command_code;
    tok.pb      = payload_byte;
    tok_vld     = first_item | pb_ok | last_item;

    // frame end returns to the idle state
    cnt_nxt = last_item ? '0 : cnt1;
    err_nxt = last_item ? 1'b0 : err1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= 1'b0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

// File: src/cfb_back.sv
// ----------------------------------------------------------------------------
// cfb_back
// Walks each segment byte by byte, runs the CRC and writes result words.
// ----------------------------------------------------------------------------
module cfb_back
  import cfb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok,
  input  logic tok_empty,
  output logic tok_pop,
  output res_t res,
  output logic res_push,
  input  logic res_full
);

  typedef enum logic [2:0] {
    ST_ID_LO, ST_ID_HI, ST_CMD, ST_PB, ST_CRC_LO, ST_CRC_HI, ST_ERR
  } step_t;

  logic        busy_r, busy_nxt;
  tok_t        cur_r, cur_nxt;
  step_t       step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt;

  logic        advance, done, load;
  step_t       nstep;
  logic [15:0] crc_in, crc_upd;

  function automatic step_t end_step(input tok_t t);
    return t.end_err ? ST_ERR : ST_CRC_LO;
  endfunction

  function automatic step_t first_step(input tok_t t);
    if (t.do_hdr) begin
      return ST_ID_LO;
    end else if (t.do_pb) begin
      return ST_PB;
    end
    return end_step(t);
  endfunction

  // following step of the current segment
  always_comb begin
    nstep = ST_ERR;
    done  = 1'b0;
    case (step_r)
      ST_ID_LO: nstep = ST_ID_HI;
      ST_ID_HI: nstep = ST_CMD;
      ST_CMD, ST_PB: begin
        if (step_r == ST_CMD && cur_r.do_pb) begin
          nstep = ST_PB;
        end else if (cur_r.do_end) begin
          nstep = end_step(cur_r);
        end else begin
          done = 1'b1;
        end
      end
      ST_CRC_LO: nstep = ST_CRC_HI;
      default:   done  = 1'b1;
    endcase
  end

  always_comb begin
    res.frame_byte  = 8'h00;
    res.frame_error = 1'b0;
    res.frame_end   = 1'b0;
    case (step_r)
      ST_ID_LO: begin
        res.frame_byte  = cur_r.id_lo;
        res.frame_error = cur_r.hdr_err;
      end
      ST_ID_HI: begin
        res.frame_byte  = {6'b0, cur_r.id_hi};
        res.frame_error = cur_r.hdr_err;
      end
      ST_CMD: begin
        res.frame_byte  = cur_r.cmd;
        res.frame_error = cur_r.hdr_err;
      end
      ST_PB: begin
        res.frame_byte  = cur_r.pb;
        res.frame_error = cur_r.pb_err;
      end
      ST_CRC_LO: res.frame_byte = crc_r[7:0];
      ST_CRC_HI: begin
        res.frame_byte = crc_r[15:8];
        res.frame_end  = 1'b1;
      end
      default: begin
        res.frame_error = 1'b1;
        res.frame_end   = 1'b1;
      end
    endcase
  end

  assign crc_in  = (step_r == ST_ID_LO) ? CRC_SEED : crc_r;
  assign crc_upd = crc_byte(crc_in, res.frame_byte);

  assign advance  = busy_r && !res_full;
  assign res_push = advance;
  assign load     = (!busy_r || (advance && done)) && !tok_empty;
  assign tok_pop  = load;

  always_comb begin
    busy_nxt = busy_r;
    cur_nxt  = cur_r;
    step_nxt = step_r;
    crc_nxt  = crc_r;
    if (advance) begin
      case (step_r)
        ST_CRC_LO: crc_nxt = crc_r;
        ST_CRC_HI: crc_nxt = CRC_SEED;
        ST_ERR:    crc_nxt = CRC_SEED;
        default:   crc_nxt = crc_upd;
      endcase
      step_nxt = nstep;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      cur_nxt  = tok;
      step_nxt = first_step(tok);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= ST_ID_LO;
      crc_r  <= CRC_SEED;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      crc_r  <= crc_nxt;
    end
    cur_r <= cur_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written into a full queue");

  a_seed_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.frame_end) |=> (crc_r == CRC_SEED))
    else $error("CRC not back at seed after frame end");

  a_crc_only_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && (step_r == ST_CRC_LO || step_r == ST_CRC_HI)) |-> !cur_r.end_err)
    else $error("CRC bytes sent on an errored frame");

endmodule

// File: tb/command_frame_builder_crc16_tb.sv
// ----------------------------------------------------------------------------
// command_frame_builder_crc16_tb
// Self-checking bench for the command frame builder. Input words are pushed
// through the in_ queue with random gaps, and result words are popped with
// random stalls. A scoreboard object keeps its own copy of the frame state.
// That state is the running CRC, the payload byte count and the error flag.
// For each accepted input word the scoreboard predicts the result words,
// and it checks every popped word against the oldest prediction. A directed
// opening covers the id and byte extremes, words outside a frame, restarts
// and error frames, then a payload that reaches and passes the limit.
// Random short frames follow, mixed with noise and unterminated frames.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfb_pkg::*;

  localparam int          BYTE_CAP    = PAYLOAD_LIMIT_DEF;
  localparam int          WORD_TARGET = 220;
  localparam int          DRAIN_WAIT  = 20;      // cycles after the last result
  localparam int unsigned CYCLE_LIMIT = 400000;

  // --------------------------------------------------------------------------
  // Scoreboard: frame state predictor plus queue of awaited result words
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [15:0] crc_acc;
    int unsigned bytes_in_frame;
    bit          frame_bad;
    res_t        awaited[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      crc_acc        = CRC_SEED;
      bytes_in_frame = 0;
      frame_bad      = 1'b0;
    endfunction

    // reflected CRC, bit at a time: feedback is lsb of crc xor data bit
    function logic [15:0] fold(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = {1'b0, c[15:1]};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void expect_word(logic [7:0] b, logic err, logic fin);
      res_t r;
      r.frame_byte  = b;
      r.frame_error = err;
      r.frame_end   = fin;
      awaited.push_back(r);
    endfunction

    // data byte: goes through the CRC and out with the current error flag
    function void send_byte(logic [7:0] b);
      crc_acc = fold(crc_acc, b);
      expect_word(b, frame_bad, 1'b0);
    endfunction

    // one accepted input word: header, then payload, then frame end
    function void note_word(logic [15:0] id, logic [7:0] cmd, logic [7:0] pb,
                            logic has, logic opens, logic closes);
      if (opens) begin
        restart();
        frame_bad = (id > ID_MAX);
        send_byte(id[7:0]);
        send_byte({6'd0, id[9:8]});
        send_byte(cmd);
      end
      if (has && bytes_in_frame < BYTE_CAP) begin
        bytes_in_frame++;
        if (bytes_in_frame == BYTE_CAP) frame_bad = 1'b1;
        send_byte(pb);
      end
      if (closes) begin
        if (frame_bad) begin
          expect_word(8'h00, 1'b1, 1'b1);
        end else begin
          expect_word(crc_acc[7:0], 1'b0, 1'b0);
          expect_word(crc_acc[15:8], 1'b0, 1'b1);
        end
        restart();
      end
    endfunction

    function void check_result(logic [7:0] fb, logic fe, logic fin);
      res_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, got byte %02h err %0b end %0b",
                 $time, fb, fe, fin);
        return;
      end
      want = awaited.pop_front();
      if (fb !== want.frame_byte) begin
        mismatches++;
        $display("%0t: frame_byte: expected %02h, got %02h", $time, want.frame_byte, fb);
      end
      if (fe !== want.frame_error) begin
        mismatches++;
        $display("%0t: frame_error: expected %0b, got %0b", $time, want.frame_error, fe);
      end
      if (fin !== want.frame_end) begin
        mismatches++;
        $display("%0t: frame_end: expected %0b, got %0b", $time, want.frame_end, fin);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [15:0] in_target_id;
  logic [7:0]  in_command_code;
  logic [7:0]  in_payload_byte;
  logic        in_has_byte;
  logic        in_first_item;
  logic        in_last_item;
  logic        empty;
  logic        pop;
  logic [7:0]  out_frame_byte;
  logic        out_frame_error;
  logic        out_frame_end;

  command_frame_builder_crc16 uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_target_id    (in_target_id),
    .in_command_code (in_command_code),
    .in_payload_byte (in_payload_byte),
    .in_has_byte     (in_has_byte),
    .in_first_item   (in_first_item),
    .in_last_item    (in_last_item),
    .empty           (empty),
    .pop             (pop),
    .out_frame_byte  (out_frame_byte),
    .out_frame_error (out_frame_error),
    .out_frame_end   (out_frame_end)
  );

  frame_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned words_sent  = 0;   // words carrying at least one flag
  bit          tx_calm     = 1'b0; // no sender gaps while set
  bit          rx_calm     = 1'b0; // no receiver stalls while set

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // watchdog: a hang or a lost result word ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("command_frame_builder_crc16_tb: done, errors");
      $finish;
    end
  end

  // result monitor: a word moves when pop is high and empty is low
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_frame_byte, out_frame_error, out_frame_end);
  end

  // receiver: random stalls on pop, with calm stretches
  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = rx_calm ? 0 : pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  // push one word; it is noted in the scoreboard once full is seen low
  task automatic send_word(input logic [15:0] id, input logic [7:0] cmd,
                           input logic [7:0] pb, input logic has,
                           input logic opens, input logic closes);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_target_id    <= id;
    in_command_code <= cmd;
    in_payload_byte <= pb;
    in_has_byte     <= has;
    in_first_item   <= opens;
    in_last_item    <= closes;
    push            <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_word(id, cmd, pb, has, opens, closes);
    if (has || opens || closes) words_sent++;
  endtask

  // hold off until every awaited word is out, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // well-formed frame with random content; header and closing word may
  // carry payload bytes; id/cmd on non-header words are junk and ignored
  task automatic send_frame(input int len, input bit closed);
    logic [15:0] id;
    int          left;
    bit          carry;
    bit          closes;
    id    = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
    left  = len;
    carry = (left > 0) && $urandom_range(0, 1);
    left  = left - carry;
    closes = closed && (left == 0) && ($urandom_range(0, 2) == 0);
    send_word(id, 8'($urandom), 8'($urandom), carry, 1'b1, closes);
    if (closes) return;
    while (left > 0) begin
      // the odd word with no byte in the middle of a frame
      if ($urandom_range(0, 15) == 0)
        send_word(16'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b0);
      left--;
      closes = closed && (left == 0) && $urandom_range(0, 1);
      send_word(16'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0, closes);
      if (closes) return;
    end
    if (closed) send_word(16'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    rst_n           = 1'b0;
    push            = 1'b0;
    in_target_id    = '0;
    in_command_code = '0;
    in_payload_byte = '0;
    in_has_byte     = 1'b0;
    in_first_item   = 1'b0;
    in_last_item    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: bytes with no header, straight after reset, build on the seed
    send_word(16'h0000, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0);
    send_word(16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
    // word with no flags: no result, no state change
    send_word(16'hFFFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0);
    // plain frame at the low extremes
    send_word(16'h0000, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
    send_word(16'h0000, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
    send_word(16'h0000, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0);
    send_word(16'h0000, 8'h00, 8'hA5, 1'b1, 1'b0, 1'b1);
    // whole frame in one word, highest good id: six results
    send_word(16'd1023, 8'hFF, 8'h5A, 1'b1, 1'b1, 1'b1);
    // lowest bad id: header still sent, error word instead of the CRC
    send_word(16'd1024, 8'h81, 8'h00, 1'b0, 1'b1, 1'b0);
    send_word(16'h0000, 8'h00, 8'h3C, 1'b1, 1'b0, 1'b0);
    send_word(16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
    // all-ones id in a one-word frame with a byte
    send_word(16'hFFFF, 8'h00, 8'hC3, 1'b1, 1'b1, 1'b1);
    // header only, then closed
    send_word(16'h03FF, 8'h7E, 8'h00, 1'b0, 1'b1, 1'b1);
    // new header in mid-frame restarts the CRC
    send_word(16'h0155, 8'hAA, 8'h00, 1'b0, 1'b1, 1'b0);
    send_word(16'h0000, 8'h00, 8'h96, 1'b1, 1'b0, 1'b0);
    send_word(16'h02AA, 8'h55, 8'h69, 1'b1, 1'b1, 1'b0);
    send_word(16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
    // close with nothing open: CRC of the bare seed
    send_word(16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
    // bad id, then a good restart clears the error
    send_word(16'h8000, 8'h01, 8'h00, 1'b0, 1'b1, 1'b0);
    send_word(16'h0005, 8'h02, 8'h11, 1'b1, 1'b1, 1'b0);
    send_word(16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);

    // sender waits here for every result word to come back
    drain();

    // payload that hits the limit and runs past it (dropped bytes)
    send_frame(BYTE_CAP + 3, 1'b1);

    // random part: mostly well-formed short frames, some noise and cut frames
    while (words_sent < WORD_TARGET) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 75) begin
        send_frame($urandom_range(0, 8), 1'b1);
      end else if (pick < 88) begin
        send_frame($urandom_range(0, 5), 1'b0);
      end else begin
        send_word(16'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom), 1'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 49) == 0) drain();
    end

    // wind down: everything popped, then a quiet spell for stray words
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    drain();
    if (sb.mismatches == 0) begin
      $display("command_frame_builder_crc16_tb: done, clean");
    end else begin
      $display("command_frame_builder_crc16_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/cfb_pkg.sv
src/cfb_fifo.sv
src/cfb_front.sv
src/cfb_back.sv
src/command_frame_builder_crc16.sv
tb/command_frame_builder_crc16_tb.sv
